/* src/dns_a_record_responder_core_macros.svh */
// Assertion macros for the responder's top-level RTL file.
`ifndef DNS_A_RECORD_RESPONDER_CORE_MACROS_SVH
`define DNS_A_RECORD_RESPONDER_CORE_MACROS_SVH
`ifndef SYNTH
`define DAR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dar: implication check failed");
`define DAR_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("dar: forbidden condition seen");
`else
`define DAR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DAR_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

/* src/dar_pkg.sv */
package dar_pkg;

   localparam int MAX_MESSAGE_BYTES_DEFAULT = 512;
   localparam int QUEUE_DEPTH_DEFAULT       = 4;

   localparam int OFFSET_W   = 10;
   localparam int DATA_W     = 8;
   localparam int VERDICT_W  = 2;
   localparam int ADDRESS_W  = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int IDX_W      = 4;

   localparam int HEADER_LEN   = 12;
   localparam int A_RECORD_LEN = 16;

   localparam logic [DATA_W-1:0] FLAGS_REPLY    = 8'h84;
   localparam logic [DATA_W-1:0] QR_MASK        = 8'h80;
   localparam logic [3:0]        OPCODE_MASK    = 4'h0f;
   localparam logic [DATA_W-1:0] LABEL_PTR_MASK = 8'hc0;
   localparam logic [DATA_W-1:0] NAME_PTR_HI    = 8'hc0;
   localparam logic [DATA_W-1:0] NAME_PTR_LO    = 8'h0c;
   localparam logic [DATA_W-1:0] TTL_SECONDS    = 8'd60;
   localparam logic [DATA_W-1:0] RDLENGTH_LO    = 8'h04;
   localparam logic [15:0]       QTYPE_A        = 16'h0001;
   localparam logic [15:0]       QCLASS_IN      = 16'h0001;

   localparam logic [VERDICT_W-1:0] VERDICT_WRITE     = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_REJECT    = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_NO_ANSWER = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_ANSWER    = 2'd3;

   localparam logic [0:0] CSR_IDX_ANSWER_ADDRESS = 1'b0;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LABEL_LEN,
      PH_LABEL_BODY,
      PH_TAIL,
      PH_DONE
   } parse_phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HEADER,
      BK_ANSWER,
      BK_STATUS
   } back_state_type;

   // One queue entry: an optional question byte write and an optional end-of-message job.
   typedef struct packed {
      logic                has_write;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   data;
      logic                has_finish;
      logic                ok;
      logic                ans;
      logic [OFFSET_W-1:0] qend;
      logic [DATA_W-1:0]   id_hi;
      logic [DATA_W-1:0]   id_lo;
      logic                rd;
   } job_type;

   function automatic logic [DATA_W-1:0] header_byte(input logic [IDX_W-1:0] idx,
                                                     input logic [DATA_W-1:0] id_hi,
                                                     input logic [DATA_W-1:0] id_lo,
                                                     input logic rd,
                                                     input logic ans);
      logic [DATA_W-1:0] value;
      value = '0;
      case (idx)
         4'd0:    value = id_hi;
         4'd1:    value = id_lo;
         4'd2:    value = FLAGS_REPLY | {7'd0, rd};
         4'd5:    value = 8'd1;
         4'd7:    value = {7'd0, ans};
         default: value = '0;
      endcase
      return value;
   endfunction

   function automatic logic [DATA_W-1:0] answer_byte(input logic [IDX_W-1:0] idx,
                                                     input logic [ADDRESS_W-1:0] addr);
      logic [DATA_W-1:0] value;
      value = '0;
      case (idx)
         4'd0:    value = NAME_PTR_HI;
         4'd1:    value = NAME_PTR_LO;
         4'd3:    value = QTYPE_A[7:0];
         4'd5:    value = QCLASS_IN[7:0];
         4'd9:    value = TTL_SECONDS;
         4'd11:   value = RDLENGTH_LO;
         4'd12:   value = addr[31:24];
         4'd13:   value = addr[23:16];
         4'd14:   value = addr[15:8];
         4'd15:   value = addr[7:0];
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

/* src/dar_if.sv */
interface dar_req_if;
   import dar_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] message_byte;
   logic              final_byte;

   modport source (output valid, output message_byte, output final_byte, input ready);
   modport sink   (input valid, input message_byte, input final_byte, output ready);
endinterface

interface dar_rsp_if;
   import dar_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OFFSET_W-1:0]  write_offset;
   logic [DATA_W-1:0]    write_data;
   logic                 write_valid;
   logic [OFFSET_W-1:0]  reply_length;
   logic [VERDICT_W-1:0] verdict;
   logic                 run_end;

   modport source (output valid, output write_offset, output write_data, output write_valid,
                   output reply_length, output verdict, output run_end, input ready);
   modport sink   (input valid, input write_offset, input write_data, input write_valid,
                   input reply_length, input verdict, input run_end, output ready);
endinterface

/* src/dar_queue.sv */
module dar_queue #(
   parameter int DEPTH = dar_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             pop_valid
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

/* src/dar_front.sv */
module dar_front #(
   parameter int MAX_MESSAGE_BYTES = dar_pkg::MAX_MESSAGE_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   dar_req_if.sink          req,
   output dar_pkg::job_type job,
   output logic             job_push,
   input  logic             job_ready
);
   import dar_pkg::*;

   // The count saturates one past the maximum; the question end may reach six past it.
   localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 2);
   localparam int QE_W  = $clog2(MAX_MESSAGE_BYTES + 23);

   logic [CNT_W-1:0]  count_ff, count_in;
   parse_phase_type   phase_ff, phase_in;
   logic [DATA_W-1:0] remain_ff, remain_in;
   logic [QE_W-1:0]   qend_ff, qend_in;
   logic [15:0]       qtype_ff, qtype_in;
   logic [15:0]       qclass_ff, qclass_in;
   logic [1:0]        tail_idx_ff, tail_idx_in;
   logic              malformed_ff, malformed_in;
   logic [DATA_W-1:0] id_hi_ff, id_hi_in;
   logic [DATA_W-1:0] id_lo_ff, id_lo_in;
   logic [DATA_W-1:0] flags_ff, flags_in;
   logic [DATA_W-1:0] qd_hi_ff, qd_hi_in;
   logic [DATA_W-1:0] qd_lo_ff, qd_lo_in;

   logic              accept;
   logic              emit;
   logic              has_write;
   logic              ok;
   logic              ans;
   logic [DATA_W-1:0] b;
   logic [CNT_W-1:0]  c;

   assign b         = req.message_byte;
   assign c         = count_ff;
   assign req.ready = job_ready;
   assign accept    = req.valid && job_ready;
   assign has_write = emit && (c < CNT_W'(MAX_MESSAGE_BYTES));
   assign job_push  = accept && (has_write || req.final_byte);

   always_comb begin
      phase_in     = phase_ff;
      remain_in    = remain_ff;
      qend_in      = qend_ff;
      qtype_in     = qtype_ff;
      qclass_in    = qclass_ff;
      tail_idx_in  = tail_idx_ff;
      malformed_in = malformed_ff;
      id_hi_in     = id_hi_ff;
      id_lo_in     = id_lo_ff;
      flags_in     = flags_ff;
      qd_hi_in     = qd_hi_ff;
      qd_lo_in     = qd_lo_ff;
      emit         = 1'b0;

      if (!malformed_ff) begin
         unique case (phase_ff)
            PH_HEADER: begin
               case (c)
                  CNT_W'(0): id_hi_in = b;
                  CNT_W'(1): id_lo_in = b;
                  CNT_W'(2): flags_in = b;
                  CNT_W'(4): qd_hi_in = b;
                  CNT_W'(5): qd_lo_in = b;
                  default:   ;
               endcase
               if (c >= CNT_W'(HEADER_LEN - 1)) begin
                  phase_in = PH_LABEL_LEN;
               end
            end
            PH_LABEL_LEN: begin
               if (b == '0) begin
                  qend_in     = QE_W'(c) + QE_W'(5);
                  tail_idx_in = '0;
                  phase_in    = PH_TAIL;
                  emit        = 1'b1;
               end else if ((b & LABEL_PTR_MASK) != '0) begin
                  malformed_in = 1'b1;
               end else begin
                  remain_in = b;
                  phase_in  = PH_LABEL_BODY;
                  emit      = 1'b1;
               end
            end
            PH_LABEL_BODY: begin
               emit      = 1'b1;
               remain_in = remain_ff - 8'd1;
               if (remain_ff == 8'd1) begin
                  phase_in = PH_LABEL_LEN;
               end
            end
            PH_TAIL: begin
               emit        = 1'b1;
               tail_idx_in = tail_idx_ff + 2'd1;
               if (!tail_idx_ff[1]) begin
                  qtype_in = {qtype_ff[7:0], b};
               end else begin
                  qclass_in = {qclass_ff[7:0], b};
               end
               if (QE_W'(c) + QE_W'(1) >= qend_ff) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end

      count_in = (c <= CNT_W'(MAX_MESSAGE_BYTES)) ? c + CNT_W'(1) : c;

      // The header fields checked here are all captured well before the twelfth byte.
      ok = (count_in >= CNT_W'(HEADER_LEN)) && (count_in <= CNT_W'(MAX_MESSAGE_BYTES))
           && ((flags_ff & QR_MASK) == '0) && ((flags_ff[6:3] & OPCODE_MASK) == '0)
           && (qd_hi_ff == '0) && (qd_lo_ff == 8'd1)
           && !malformed_in && (phase_in == PH_DONE);
      ans = (qtype_in == QTYPE_A) && (qclass_in == QCLASS_IN)
            && (qend_in + QE_W'(A_RECORD_LEN) <= QE_W'(MAX_MESSAGE_BYTES));

      job.has_write  = has_write;
      job.offset     = OFFSET_W'(c);
      job.data       = b;
      job.has_finish = req.final_byte;
      job.ok         = ok;
      job.ans        = ans;
      job.qend       = OFFSET_W'(qend_in);
      job.id_hi      = id_hi_ff;
      job.id_lo      = id_lo_ff;
      job.rd         = flags_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         phase_ff     <= PH_HEADER;
         remain_ff    <= '0;
         qend_ff      <= '0;
         qtype_ff     <= '0;
         qclass_ff    <= '0;
         tail_idx_ff  <= '0;
         malformed_ff <= 1'b0;
      end else if (accept) begin
         if (req.final_byte) begin
            count_ff     <= '0;
            phase_ff     <= PH_HEADER;
            remain_ff    <= '0;
            qend_ff      <= '0;
            qtype_ff     <= '0;
            qclass_ff    <= '0;
            tail_idx_ff  <= '0;
            malformed_ff <= 1'b0;
         end else begin
            count_ff     <= count_in;
            phase_ff     <= phase_in;
            remain_ff    <= remain_in;
            qend_ff      <= qend_in;
            qtype_ff     <= qtype_in;
            qclass_ff    <= qclass_in;
            tail_idx_ff  <= tail_idx_in;
            malformed_ff <= malformed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         id_hi_ff <= id_hi_in;
         id_lo_ff <= id_lo_in;
         flags_ff <= flags_in;
         qd_hi_ff <= qd_hi_in;
         qd_lo_ff <= qd_lo_in;
      end
   end
endmodule

/* src/dar_back.sv */
module dar_back (
   input  logic                             clock,
   input  logic                             reset,
   input  dar_pkg::job_type                 job,
   input  logic                             job_valid,
   output logic                             job_pop,
   input  logic [dar_pkg::ADDRESS_W-1:0]    answer_address,
   dar_rsp_if.source                        rsp
);
   import dar_pkg::*;

   back_state_type       state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   job_type              cur_ff, cur_in;
   logic                 out_valid_ff, out_valid_in;
   logic [OFFSET_W-1:0]  out_offset_ff;
   logic [DATA_W-1:0]    out_data_ff;
   logic                 out_write_ff;
   logic [OFFSET_W-1:0]  out_len_ff;
   logic [VERDICT_W-1:0] out_verdict_ff;
   logic                 out_end_ff;

   logic                 out_free;
   logic                 gen_valid;
   logic [OFFSET_W-1:0]  gen_offset;
   logic [DATA_W-1:0]    gen_data;
   logic                 gen_write;
   logic [OFFSET_W-1:0]  gen_len;
   logic [VERDICT_W-1:0] gen_verdict;
   logic                 gen_end;

   // The output register frees up when it is empty or its transfer completes this cycle.
   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      cur_in      = cur_ff;
      job_pop     = 1'b0;
      gen_valid   = 1'b0;
      gen_offset  = '0;
      gen_data    = '0;
      gen_write   = 1'b1;
      gen_len     = '0;
      gen_verdict = VERDICT_WRITE;
      gen_end     = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid && out_free) begin
               job_pop = 1'b1;
               cur_in  = job;
               idx_in  = '0;
               if (job.has_write) begin
                  gen_valid  = 1'b1;
                  gen_offset = job.offset;
                  gen_data   = job.data;
                  gen_end    = !job.has_finish;
               end
               if (job.has_finish) begin
                  state_in = job.ok ? BK_HEADER : BK_STATUS;
               end
            end
         end
         BK_HEADER: begin
            if (out_free) begin
               gen_valid  = 1'b1;
               gen_offset = OFFSET_W'(idx_ff);
               gen_data   = header_byte(idx_ff, cur_ff.id_hi, cur_ff.id_lo, cur_ff.rd,
                                        cur_ff.ans);
               idx_in     = idx_ff + IDX_W'(1);
               if (idx_ff == IDX_W'(HEADER_LEN - 1)) begin
                  idx_in   = '0;
                  state_in = cur_ff.ans ? BK_ANSWER : BK_STATUS;
               end
            end
         end
         BK_ANSWER: begin
            if (out_free) begin
               gen_valid  = 1'b1;
               gen_offset = cur_ff.qend + OFFSET_W'(idx_ff);
               gen_data   = answer_byte(idx_ff, answer_address);
               idx_in     = idx_ff + IDX_W'(1);
               if (idx_ff == IDX_W'(A_RECORD_LEN - 1)) begin
                  idx_in   = '0;
                  state_in = BK_STATUS;
               end
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               gen_valid = 1'b1;
               gen_write = 1'b0;
               gen_end   = 1'b1;
               if (!cur_ff.ok) begin
                  gen_verdict = VERDICT_REJECT;
               end else if (cur_ff.ans) begin
                  gen_verdict = VERDICT_ANSWER;
                  gen_len     = cur_ff.qend + OFFSET_W'(A_RECORD_LEN);
               end else begin
                  gen_verdict = VERDICT_NO_ANSWER;
                  gen_len     = cur_ff.qend;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      out_valid_in = out_free ? gen_valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (out_free && gen_valid) begin
         out_offset_ff  <= gen_offset;
         out_data_ff    <= gen_data;
         out_write_ff   <= gen_write;
         out_len_ff     <= gen_len;
         out_verdict_ff <= gen_verdict;
         out_end_ff     <= gen_end;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.write_offset = out_offset_ff;
   assign rsp.write_data   = out_data_ff;
   assign rsp.write_valid  = out_write_ff;
   assign rsp.reply_length = out_len_ff;
   assign rsp.verdict      = out_verdict_ff;
   assign rsp.run_end      = out_end_ff;
endmodule

/* src/dns_a_record_responder_core.sv */
// A question byte's write reaches the result port through the job queue and the output register.
// Throughput: one query byte per cycle; intake stalls only when the job queue (default 4) fills.
// The final byte adds up to 30 results (its own write, 12 header, 16 answer, status) at one per
// cycle while the result port is ready, none in the cycle its job is taken if it writes nothing.
// Reset: synchronous, active high; clears parse state, queue and output register, and sets
// answer_address to 0. No clearing pass is needed, so items are taken the cycle after reset.
`include "dns_a_record_responder_core_macros.svh"

module dns_a_record_responder_core #(
   parameter int MAX_MESSAGE_BYTES = dar_pkg::MAX_MESSAGE_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH       = dar_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   dar_req_if.sink                         req_chan,
   dar_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dar_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [dar_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [dar_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import dar_pkg::*;

   localparam int JOB_W = $bits(job_type);

   logic [ADDRESS_W-1:0] answer_address_ff, answer_address_in;
   logic [0:0]           csr_index;
   logic                 csr_write;

   job_type              push_job;
   job_type              pop_job;
   logic [JOB_W-1:0]     pop_bits;
   logic                 q_push, q_push_ready;
   logic                 q_pop, q_pop_valid;

   logic                 status_out;
   logic                 kind_agrees;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      answer_address_in = answer_address_ff;
      if (csr_write && (csr_index == CSR_IDX_ANSWER_ADDRESS)) begin
         answer_address_in = pwdata;
      end
      prdata = (csr_index == CSR_IDX_ANSWER_ADDRESS) ? answer_address_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         answer_address_ff <= '0;
      end else begin
         answer_address_ff <= answer_address_in;
      end
   end

   dar_front #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .job       (push_job),
      .job_push  (q_push),
      .job_ready (q_push_ready)
   );

   dar_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (push_job),
      .push_ready (q_push_ready),
      .pop        (q_pop),
      .pop_data   (pop_bits),
      .pop_valid  (q_pop_valid)
   );

   assign pop_job = job_type'(pop_bits);

   dar_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job            (pop_job),
      .job_valid      (q_pop_valid),
      .job_pop        (q_pop),
      .answer_address (answer_address_ff),
      .rsp            (rsp_chan)
   );

   assign status_out  = rsp_chan.valid && !rsp_chan.write_valid;
   assign kind_agrees = rsp_chan.write_valid == (rsp_chan.verdict == VERDICT_WRITE);

   `DAR_ASSERT_NEVER(a_queue_no_overflow, clock, reset, q_push && !q_push_ready)
   `DAR_ASSERT_NEVER(a_queue_no_underflow, clock, reset, q_pop && !q_pop_valid)
   `DAR_ASSERT_IMPLY(a_status_ends_run, clock, reset, status_out, rsp_chan.run_end)
   `DAR_ASSERT_IMPLY(a_verdict_matches_kind, clock, reset, rsp_chan.valid, kind_agrees)
endmodule
